/* hdl/xve_pkg.sv */
// Shared types, constants and the round-count table for the message encryptor.
// No dependencies; imported by every module of the block.
package xve_pkg;

  localparam int MAX_DATA_WORDS = 63;
  localparam int STORE_DEPTH    = MAX_DATA_WORDS + 1;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int COUNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int WORD_W         = 32;
  localparam int TOTAL_W        = 8;
  localparam int ROUNDS_W       = 6;
  localparam int NB_W           = 3;
  localparam int KEY_IDX_W      = 2;

  localparam logic [WORD_W-1:0] CIPHER_DELTA = 32'h9E37_79B9;
  localparam logic [NB_W-1:0]   NB_FULL      = 3'd4;

  localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD0 = 2'd0;
  localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD1 = 2'd1;
  localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD2 = 2'd2;
  localparam logic [KEY_IDX_W-1:0] REG_KEY_WORD3 = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LOAD0,
    ST_ROUND,
    ST_RD,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    MIX_SUM,
    MIX_SHIFT,
    MIX_KEY,
    MIX_ACC
  } mix_op_t;

  typedef struct packed {
    mix_op_t           op;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] key;
  } mix_req_t;

  typedef logic [3:0][WORD_W-1:0] key_set_t;

  // 6 + 52/(n+1) for a message of n+1 words
  function automatic logic [ROUNDS_W-1:0] rounds_for(input logic [ADDR_W-1:0] n);
    logic [ROUNDS_W-1:0] r;
    begin
      if (n == ADDR_W'(0))       r = ROUNDS_W'(58);
      else if (n == ADDR_W'(1))  r = ROUNDS_W'(32);
      else if (n == ADDR_W'(2))  r = ROUNDS_W'(23);
      else if (n == ADDR_W'(3))  r = ROUNDS_W'(19);
      else if (n == ADDR_W'(4))  r = ROUNDS_W'(16);
      else if (n == ADDR_W'(5))  r = ROUNDS_W'(14);
      else if (n == ADDR_W'(6))  r = ROUNDS_W'(13);
      else if (n == ADDR_W'(7))  r = ROUNDS_W'(12);
      else if (n <= ADDR_W'(9))  r = ROUNDS_W'(11);
      else if (n <= ADDR_W'(12)) r = ROUNDS_W'(10);
      else if (n <= ADDR_W'(16)) r = ROUNDS_W'(9);
      else if (n <= ADDR_W'(25)) r = ROUNDS_W'(8);
      else if (n <= ADDR_W'(51)) r = ROUNDS_W'(7);
      else                       r = ROUNDS_W'(6);
      return r;
    end
  endfunction

endpackage

/* hdl/xxtea_variant_message_encrypt.sv */
// Top level of the message encryptor: key registers and the cipher core.
// Depends on xve_pkg and xve_core.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_stall    data_word, valid_bytes, final_word
//   output   out        out_valid/out_stall  cipher_word, last_out, empty_message
//   config   in         cfg_we               cfg_index, cfg_data
//
// Non-final words are accepted back to back while idle. A final word of a non-empty
// message runs R rounds, R = 6 + 52/(N+1), N+1 the stored words plus the length word:
// set-up in ST_SETUP and ST_LOAD0, then per round ST_ROUND for the sum and ST_RD,
// ST_M1, ST_M2, ST_M3 per word update on the one memory read port and the shared adder.
// Each result then passes ST_OUT_RD, ST_OUT_LOAD and ST_OUT_WAIT, plus any output stall.
// Reset clears the word count, byte total, keys and output valid; no clearing pass.
// The input is stalled from a final word until its last result is taken.
module xxtea_variant_message_encrypt
  import xve_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    data_word,
  input  logic [NB_W-1:0]      valid_bytes,
  input  logic                 final_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    cipher_word,
  output logic                 last_out,
  output logic                 empty_message
);

  key_set_t keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_WORD0: keys[0] <= cfg_data;
        REG_KEY_WORD1: keys[1] <= cfg_data;
        REG_KEY_WORD2: keys[2] <= cfg_data;
        REG_KEY_WORD3: keys[3] <= cfg_data;
        default:       keys    <= keys;
      endcase
    end
  end

  xve_core u_core (
    .clk           (clk),
    .rst           (rst),
    .keys          (keys),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_word     (data_word),
    .valid_bytes   (valid_bytes),
    .final_word    (final_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cipher_word   (cipher_word),
    .last_out      (last_out),
    .empty_message (empty_message)
  );

endmodule

/* hdl/xve_store.sv */
// Word store: one write port, one registered read port.
// Depends on xve_pkg for depth and widths.
module xve_store
  import xve_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/xve_mix.sv */
// Shared 32-bit adder with operand selection for the cipher's mixing steps.
// Depends on xve_pkg for the request struct and operation codes.
module xve_mix
  import xve_pkg::*;
(
  input  mix_req_t          req,
  output logic [WORD_W-1:0] res
);

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;

  always_comb begin
    case (req.op)
      MIX_SUM: begin
        a = req.sum;
        b = CIPHER_DELTA;
      end
      MIX_SHIFT: begin
        a = (req.z >> 5) ^ (req.y << 2);
        b = ((req.y >> 3) ^ (req.z << 4)) ^ (req.sum ^ req.y);
      end
      MIX_KEY: begin
        a = req.t;
        b = req.key ^ req.z;
      end
      MIX_ACC: begin
        a = req.x;
        b = req.t;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign res = a + b;

endmodule

/* hdl/xve_core.sv */
// Sequencer and datapath: gathers words, runs the rounds through the shared adder,
// and streams the enciphered words out. Uses xve_pkg, xve_store and xve_mix.
module xve_core
  import xve_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  key_set_t          keys,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] data_word,
  input  logic [NB_W-1:0]   valid_bytes,
  input  logic              final_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] cipher_word,
  output logic              last_out,
  output logic              empty_message
);

  state_t state;
  state_t state_next;

  logic [COUNT_W-1:0]  count;
  logic [TOTAL_W-1:0]  total;
  logic [ROUNDS_W-1:0] rounds;
  logic [WORD_W-1:0]   sum;
  logic [WORD_W-1:0]   z;
  logic [WORD_W-1:0]   x;
  logic [WORD_W-1:0]   y;
  logic [WORD_W-1:0]   t;
  logic [ADDR_W-1:0]   p;

  logic [ADDR_W-1:0] n;
  logic              in_acc;
  logic [NB_W-1:0]   nb;
  logic              do_store;
  logic [WORD_W-1:0] masked;
  logic [TOTAL_W-1:0] total_next;
  logic              p_at_end;
  logic [ADDR_W-1:0] p_succ;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  mix_req_t          mreq;
  logic [WORD_W-1:0] mres;

  assign n        = count[ADDR_W-1:0];
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign nb       = (valid_bytes > NB_FULL) ? NB_FULL : valid_bytes;
  assign do_store = (nb != '0) && (count < COUNT_W'(MAX_DATA_WORDS));
  assign total_next = do_store ? total + TOTAL_W'(nb) : total;
  assign p_at_end = (p == n);
  assign p_succ   = p_at_end ? '0 : p + ADDR_W'(1);

  always_comb begin
    case (nb)
      3'd1:    masked = {24'b0, data_word[7:0]};
      3'd2:    masked = {16'b0, data_word[15:0]};
      3'd3:    masked = {8'b0, data_word[23:0]};
      default: masked = data_word;
    endcase
  end

  xve_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  xve_mix u_mix (
    .req (mreq),
    .res (mres)
  );

  always_comb begin
    case (state)
      ST_IDLE: begin
        if (in_acc && final_word) begin
          state_next = (total_next == '0) ? ST_OUT_WAIT : ST_SETUP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SETUP:    state_next = ST_LOAD0;
      ST_LOAD0:    state_next = ST_ROUND;
      ST_ROUND:    state_next = ST_RD;
      ST_RD:       state_next = ST_M1;
      ST_M1:       state_next = ST_M2;
      ST_M2:       state_next = ST_M3;
      ST_M3: begin
        if (!p_at_end) begin
          state_next = ST_RD;
        end else if (rounds == '0) begin
          state_next = ST_OUT_RD;
        end else begin
          state_next = ST_ROUND;
        end
      end
      ST_OUT_RD:   state_next = ST_OUT_LOAD;
      ST_OUT_LOAD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (!out_stall) begin
          state_next = last_out ? ST_IDLE : ST_OUT_RD;
        end else begin
          state_next = ST_OUT_WAIT;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p;
    mem_wdata = mres;
    mem_raddr = '0;
    mreq.op   = MIX_SUM;
    mreq.x    = x;
    mreq.y    = mem_rdata;
    mreq.z    = z;
    mreq.sum  = sum;
    mreq.t    = t;
    mreq.key  = keys[p[KEY_IDX_W-1:0] ^ sum[3:2]];
    case (state)
      ST_IDLE: begin
        mem_we    = in_acc && do_store;
        mem_waddr = n;
        mem_wdata = masked;
      end
      ST_SETUP: begin
        mem_we    = 1'b1;
        mem_waddr = n;
        mem_wdata = WORD_W'(total);
      end
      ST_ROUND:  mreq.op = MIX_SUM;
      ST_RD:     mem_raddr = p_succ;
      ST_M1:     mreq.op = MIX_SHIFT;
      ST_M2:     mreq.op = MIX_KEY;
      ST_M3: begin
        mreq.op = MIX_ACC;
        mem_we  = 1'b1;
      end
      ST_OUT_RD: mem_raddr = p;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (do_store) begin
              count <= count + COUNT_W'(1);
              total <= total_next;
            end
            if (final_word && total_next == '0) begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_OUT_LOAD: out_valid <= 1'b1;
        ST_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_out) begin
              count <= '0;
              total <= '0;
            end
          end
        end
        default: begin
          out_valid <= out_valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc && final_word && total_next == '0) begin
          cipher_word   <= '0;
          last_out      <= 1'b1;
          empty_message <= 1'b1;
        end
      end
      ST_SETUP: begin
        z      <= WORD_W'(total);
        rounds <= rounds_for(n);
        sum    <= '0;
      end
      ST_LOAD0: x <= mem_rdata;
      ST_ROUND: begin
        sum    <= mres;
        rounds <= rounds - ROUNDS_W'(1);
        p      <= '0;
      end
      ST_M1: begin
        y <= mem_rdata;
        t <= mres;
      end
      ST_M2: t <= mres;
      ST_M3: begin
        z <= mres;
        x <= y;
        p <= p_succ;
      end
      ST_OUT_LOAD: begin
        cipher_word   <= mem_rdata;
        last_out      <= p_at_end;
        empty_message <= 1'b0;
      end
      ST_OUT_WAIT: begin
        if (!out_stall && !last_out) begin
          p <= p + ADDR_W'(1);
        end
      end
      default: begin
        t <= t;
      end
    endcase
  end

endmodule
